/* hdl/fpw_pkg.sv */
// ----------------------------------------------------------------------------
// fpw_pkg
// Shared types, constants and helpers for the four-level page walker.
// ----------------------------------------------------------------------------
package fpw_pkg;

    // Walk geometry (LEVELS: 2..5, PHYS_BITS: 32..52)
    localparam int LEVELS    = 4;
    localparam int PHYS_BITS = 52;
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int LAST_LVL  = LEVELS - 1;

    // Fixed field widths
    localparam int VA_W    = 48;
    localparam int PA_W    = 52;
    localparam int ENTRY_W = 64;
    localparam int IDX_W   = 9;
    localparam int PG_OFS  = 12;

    // Entry address bits 12..PHYS_BITS-1
    localparam logic [PA_W-1:0] ADDR_MASK =
        ((PA_W'(1) << PHYS_BITS) - PA_W'(1)) & ~PA_W'(12'hFFF);
    localparam logic [PA_W-1:0] BOUND_RESET = PA_W'(64'h10_0000_0000);

    localparam int ENT_PRESENT_BIT = 0;
    localparam int ENT_LARGE_BIT   = 7;

    typedef logic [LVL_W-1:0] t_lvl;

    typedef enum logic {
        OP_START = 1'b0,
        OP_RSP   = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FAULT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PSIZE_4K = 2'd0,
        PSIZE_2M = 2'd1,
        PSIZE_1G = 2'd2
    } t_psize;

    typedef enum logic [2:0] {
        FAULT_NONE     = 3'd0,
        FAULT_BAD_ROOT = 3'd1,
        FAULT_BOUND    = 3'd2,
        FAULT_READ_ERR = 3'd3,
        FAULT_NOT_PRES = 3'd4
    } t_fault;

    typedef struct packed {
        t_op                operation;
        logic [VA_W-1:0]    virt_addr;
        logic [PA_W-1:0]    root_table;
        logic [ENTRY_W-1:0] mem_data;
        logic               mem_error;
    } t_req;

    typedef struct packed {
        t_kind              kind;
        logic [PA_W-1:0]    read_addr;
        logic [PA_W-1:0]    phys_addr;
        logic [1:0]         walk_level;
        t_psize             page_size;
        logic [ENTRY_W-1:0] entry_value;
        t_fault             fault_reason;
    } t_rsp;

    typedef struct packed {
        logic            busy;
        logic [VA_W-1:0] vaddr;
        t_lvl            level;
    } t_walk_state;

    // 9-bit table index of a virtual address at a given level
    function automatic logic [IDX_W-1:0] idx_at(input logic [VA_W-1:0] va,
                                                input t_lvl lvl);
        logic [63:0]      vx;
        logic [IDX_W-1:0] idx;
        vx  = 64'(va);
        idx = '0;
        for (int l = 0; l < LEVELS; l++) begin
            if (lvl == t_lvl'(l)) begin
                idx = vx[PG_OFS + IDX_W * (LEVELS - 1 - l) +: IDX_W];
            end
        end
        return idx;
    endfunction

    // Level as carried on the 2-bit result field
    function automatic logic [1:0] to_walk_level(input t_lvl lvl);
        logic [2:0] w;
        w = 3'(lvl);
        return w[1:0];
    endfunction

endpackage

/* hdl/fpw_if.sv */
// ----------------------------------------------------------------------------
// fpw_in_if / fpw_out_if
// Valid/ready channels carrying walker requests and results.
// ----------------------------------------------------------------------------
interface fpw_in_if;
    logic          valid;
    logic          ready;
    fpw_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fpw_out_if;
    logic          valid;
    logic          ready;
    fpw_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/fpw_step.sv */
// ----------------------------------------------------------------------------
// fpw_step
// One walk step: checks a start or a memory response against the current
// walk state and forms the result and the next state.
// ----------------------------------------------------------------------------
module fpw_step (
    input  fpw_pkg::t_req                i_req,
    input  fpw_pkg::t_walk_state         i_state,
    input  logic [fpw_pkg::PA_W-1:0]     i_bound,
    output logic                         o_has_result,
    output fpw_pkg::t_rsp                o_result,
    output fpw_pkg::t_walk_state         o_state
);

    logic [fpw_pkg::PA_W-1:0]    root;
    logic [fpw_pkg::PA_W-1:0]    table_addr;
    logic [fpw_pkg::ENTRY_W-1:0] ent;
    fpw_pkg::t_lvl               lvl;
    fpw_pkg::t_lvl               nlvl;

    assign root       = i_req.root_table;
    assign ent        = i_req.mem_data;
    assign lvl        = i_state.level;
    assign nlvl       = lvl + fpw_pkg::t_lvl'(1);
    assign table_addr = ent[fpw_pkg::PA_W-1:0] & fpw_pkg::ADDR_MASK;

    always_comb begin
        o_has_result = 1'b0;
        o_result     = '0;
        o_state      = i_state;

        if (i_req.operation == fpw_pkg::OP_START) begin
            o_state.busy = 1'b0;
            o_has_result = 1'b1;
            if (root == '0 || root[fpw_pkg::PG_OFS-1:0] != '0 || root >= i_bound) begin
                o_result.kind         = fpw_pkg::KIND_FAULT;
                o_result.fault_reason = fpw_pkg::FAULT_BAD_ROOT;
            end else begin
                o_state.busy       = 1'b1;
                o_state.vaddr      = i_req.virt_addr;
                o_state.level      = '0;
                o_result.kind      = fpw_pkg::KIND_READ;
                o_result.read_addr = (root & fpw_pkg::ADDR_MASK) + fpw_pkg::PA_W'(
                    {fpw_pkg::idx_at(i_req.virt_addr, '0), 3'b000});
            end
        end else if (i_state.busy) begin
            o_has_result        = 1'b1;
            o_result.walk_level = fpw_pkg::to_walk_level(lvl);
            if (i_req.mem_error) begin
                o_state.busy          = 1'b0;
                o_result.kind         = fpw_pkg::KIND_FAULT;
                o_result.fault_reason = fpw_pkg::FAULT_READ_ERR;
            end else if (!ent[fpw_pkg::ENT_PRESENT_BIT]) begin
                o_state.busy          = 1'b0;
                o_result.kind         = fpw_pkg::KIND_FAULT;
                o_result.fault_reason = fpw_pkg::FAULT_NOT_PRES;
                o_result.entry_value  = ent;
            end else if (int'(lvl) >= fpw_pkg::LAST_LVL) begin
                o_state.busy         = 1'b0;
                o_result.kind        = fpw_pkg::KIND_DONE;
                o_result.page_size   = fpw_pkg::PSIZE_4K;
                o_result.entry_value = ent;
                o_result.phys_addr   = {table_addr[fpw_pkg::PA_W-1:12],
                                        i_state.vaddr[11:0]};
            end else if (ent[fpw_pkg::ENT_LARGE_BIT] && int'(lvl) >= 1
                         && int'(lvl) + 3 >= fpw_pkg::LEVELS) begin
                o_state.busy         = 1'b0;
                o_result.kind        = fpw_pkg::KIND_DONE;
                o_result.entry_value = ent;
                if (int'(lvl) + 3 == fpw_pkg::LEVELS) begin
                    o_result.page_size = fpw_pkg::PSIZE_1G;
                    o_result.phys_addr = {table_addr[fpw_pkg::PA_W-1:30],
                                          i_state.vaddr[29:0]};
                end else begin
                    o_result.page_size = fpw_pkg::PSIZE_2M;
                    o_result.phys_addr = {table_addr[fpw_pkg::PA_W-1:21],
                                          i_state.vaddr[20:0]};
                end
            end else begin
                o_result.walk_level = fpw_pkg::to_walk_level(nlvl);
                if (table_addr >= i_bound) begin
                    o_state.busy          = 1'b0;
                    o_result.kind         = fpw_pkg::KIND_FAULT;
                    o_result.fault_reason = fpw_pkg::FAULT_BOUND;
                end else begin
                    o_state.level      = nlvl;
                    o_result.kind      = fpw_pkg::KIND_READ;
                    o_result.read_addr = table_addr + fpw_pkg::PA_W'(
                        {fpw_pkg::idx_at(i_state.vaddr, nlvl), 3'b000});
                end
            end
        end
    end

endmodule

/* hdl/four_level_page_walker.sv */
// ----------------------------------------------------------------------------
// four_level_page_walker
// Page-table walker for the x86-64 four-level format.
//
// Software or a host engine sends a start request (virtual address and root
// table) and then feeds back one memory response per entry read that the
// walker asks for. Every accepted request is handled combinationally: the
// step logic sits between the request channel and one result register, so a
// new request can be taken every clock, except while a result waits for
// the consumer (ready = result register empty or being drained). A start
// yields a read request for the level-0 entry or a bad-root fault; each
// response yields the next read request, a finished translation (4 KiB,
// 2 MiB or 1 GiB page) or a fault. A response with no walk yields nothing;
// a start drops any walk. The table bound register is to be written with
// i_cfg_we only while the walker is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module four_level_page_walker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [fpw_pkg::PA_W-1:0]  i_cfg_wdata,
    fpw_in_if.sink                    i_req,
    fpw_out_if.source                 o_rsp
);

    // Table bound register
    logic [fpw_pkg::PA_W-1:0] r_bound;
    logic [fpw_pkg::PA_W-1:0] n_bound;

    // Walk state: busy flag, virtual address, current level
    fpw_pkg::t_walk_state r_state;
    fpw_pkg::t_walk_state n_state;

    // Result register; payload needs no reset
    logic          r_out_valid;
    logic          n_out_valid;
    fpw_pkg::t_rsp r_out;
    fpw_pkg::t_rsp n_out;

    logic                 req_ready;
    logic                 req_acc;
    logic                 step_has;
    fpw_pkg::t_rsp        step_res;
    fpw_pkg::t_walk_state step_state;

    // Take a request whenever the result register is free or draining
    assign req_ready   = !r_out_valid || o_rsp.ready;
    assign req_acc     = i_req.valid && req_ready;
    assign i_req.ready = req_ready;

    fpw_step u_step (
        .i_req        (i_req.data),
        .i_state      (r_state),
        .i_bound      (r_bound),
        .o_has_result (step_has),
        .o_result     (step_res),
        .o_state      (step_state)
    );

    always_comb begin
        n_bound     = r_bound;
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (i_cfg_we) begin
            n_bound = i_cfg_wdata;
        end

        // Drain first, then a new result may refill in the same cycle
        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        if (req_acc) begin
            n_state = step_state;
            if (step_has) begin
                n_out_valid = 1'b1;
                n_out       = step_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound     <= fpw_pkg::BOUND_RESET;
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_bound     <= n_bound;
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

`ifndef SYNTHESIS
    // A read request always leaves a walk in progress
    a_read_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc && step_has && step_res.kind == fpw_pkg::KIND_READ |=> r_state.busy)
        else $error("read request issued without an active walk");

    // Done or fault ends the walk
    a_end_clears_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc && step_has && step_res.kind != fpw_pkg::KIND_READ |=> !r_state.busy)
        else $error("walk still active after done or fault");

    // Only faults carry a fault reason
    a_reason_only_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind != fpw_pkg::KIND_FAULT
        |-> r_out.fault_reason == fpw_pkg::FAULT_NONE)
        else $error("fault reason set on a non-fault result");

    // Reset leaves no walk and no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_state.busy && !r_out_valid)
        else $error("walker not idle after reset");
`endif

endmodule

/* sim/four_level_page_walker_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_walker_test
// Self-checking bench for the page walker. It plays the role of memory and
// answers each entry read with a made-up entry, and it predicts every
// result. Results are compared field by field in arrival order. The run
// covers several table bounds, both ends of the range among them, with
// random idling on both channels and one long back-pressure stretch.
// ----------------------------------------------------------------------------
module four_level_page_walker_test;
    import fpw_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;  // generous
    localparam int SETTLE_CYCLES = 4;       // combinational step plus result reg
    localparam int HOLD_CYCLES   = 200;     // long consumer hold-off
    localparam int MAX_REPORTS   = 200;     // keep the log readable

    // Consumer ready behavior
    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN,
        RX_COIN
    } t_rx_mode;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            cfg_we;
    logic [PA_W-1:0] cfg_wdata;

    fpw_in_if  req_if ();
    fpw_out_if rsp_if ();

    four_level_page_walker DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Walk predictor: its own copy of the bound register and the walk state.
    // ------------------------------------------------------------------------
    logic [PA_W-1:0] table_bound = BOUND_RESET;
    bit              walk_active = 1'b0;
    logic [VA_W-1:0] walk_va     = '0;
    logic [1:0]      walk_depth  = '0;

    t_rsp expected_results[$];

    // Bookkeeping
    int n_items;        // requests that produced a result
    int n_ignored;      // responses dropped with no walk running
    int n_reads, n_done, n_fault;
    int n_4k, n_2m, n_1g;
    int n_bounds;
    int fail_count;
    int cycle_count;

    // Sender idling knobs
    int burst_left;
    int burst_max = 4;
    int gap_max   = 2;

    // Consumer knobs; hold_reqs is bumped by a test to ask for a hold-off
    t_rx_mode rx_mode = RX_RANDOM;
    int       hold_len  = HOLD_CYCLES;
    int       hold_reqs = 0;
    int       hold_seen = 0;
    int       hold_left = 0;
    int       rx_tick   = 0;

    // Byte offset of the entry slot that a VA selects at a given depth
    function automatic logic [63:0] slot_offset(input logic [VA_W-1:0] va,
                                                input logic [1:0] depth);
        int shift;
        shift = PG_OFS + IDX_W * (LAST_LVL - int'(depth));
        return ((64'(va) >> shift) & 64'h1FF) << 3;
    endfunction

    // Advance the walk by one request; returns 1 when a result is due.
    function automatic bit walk_step(input t_req r, output t_rsp res);
        logic [63:0] e;
        logic [63:0] tbl;
        logic [63:0] pmask;
        res = '0;
        if (r.operation == OP_START) begin
            walk_active = 1'b0;
            if (r.root_table == '0 || r.root_table[11:0] != 12'd0 ||
                r.root_table >= table_bound) begin
                res.kind         = KIND_FAULT;
                res.fault_reason = FAULT_BAD_ROOT;
                return 1'b1;
            end
            walk_va     = r.virt_addr;
            walk_depth  = '0;
            walk_active = 1'b1;
            res.kind      = KIND_READ;
            res.read_addr = PA_W'(64'(r.root_table) + slot_offset(walk_va, walk_depth));
            return 1'b1;
        end

        // memory response with nothing outstanding is dropped
        if (!walk_active) begin
            return 1'b0;
        end

        e              = r.mem_data;
        tbl            = e & 64'(ADDR_MASK);
        res.walk_level = walk_depth;

        if (r.mem_error) begin
            walk_active      = 1'b0;
            res.kind         = KIND_FAULT;
            res.fault_reason = FAULT_READ_ERR;
            return 1'b1;
        end
        if (!e[ENT_PRESENT_BIT]) begin
            walk_active      = 1'b0;
            res.kind         = KIND_FAULT;
            res.fault_reason = FAULT_NOT_PRES;
            res.entry_value  = e;
            return 1'b1;
        end
        // last level: always a 4 KiB page, large bit or not
        if (int'(walk_depth) >= LAST_LVL) begin
            walk_active     = 1'b0;
            res.kind        = KIND_DONE;
            res.phys_addr   = PA_W'(tbl | 64'(walk_va[11:0]));
            res.page_size   = PSIZE_4K;
            res.entry_value = e;
            return 1'b1;
        end
        // large page only counts at the 1 GiB and 2 MiB levels
        if (e[ENT_LARGE_BIT] && walk_depth != 2'd0 && int'(walk_depth) + 3 >= LEVELS) begin
            if (int'(walk_depth) + 3 == LEVELS) begin
                pmask         = 64'h3FFF_FFFF;
                res.page_size = PSIZE_1G;
            end else begin
                pmask         = 64'h1F_FFFF;
                res.page_size = PSIZE_2M;
            end
            walk_active     = 1'b0;
            res.kind        = KIND_DONE;
            res.phys_addr   = PA_W'((tbl & ~pmask) | (64'(walk_va) & pmask));
            res.entry_value = e;
            return 1'b1;
        end

        // next table: bound fault is charged to the level being entered
        walk_depth     = walk_depth + 2'd1;
        res.walk_level = walk_depth;
        if (tbl >= 64'(table_bound)) begin
            walk_active      = 1'b0;
            res.kind         = KIND_FAULT;
            res.fault_reason = FAULT_BOUND;
            return 1'b1;
        end
        res.kind      = KIND_READ;
        res.read_addr = PA_W'(tbl + slot_offset(walk_va, walk_depth));
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    function automatic void field_check(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endfunction

    function automatic void check_result(input t_rsp got);
        t_rsp want;
        if (expected_results.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result, expected none actual %h", $time, got);
            return;
        end
        want = expected_results.pop_front();
        field_check("kind",         want.kind,         got.kind);
        field_check("read_addr",    want.read_addr,    got.read_addr);
        field_check("phys_addr",    want.phys_addr,    got.phys_addr);
        field_check("walk_level",   want.walk_level,   got.walk_level);
        field_check("page_size",    want.page_size,    got.page_size);
        field_check("entry_value",  want.entry_value,  got.entry_value);
        field_check("fault_reason", want.fault_reason, got.fault_reason);
        case (got.kind)
            KIND_READ:  n_reads++;
            KIND_FAULT: n_fault++;
            default: begin
                n_done++;
                if (got.page_size == PSIZE_1G)      n_1g++;
                else if (got.page_size == PSIZE_2M) n_2m++;
                else                                n_4k++;
            end
        endcase
    endfunction

    // Consumer: check on handshake, then choose next ready.
    // A requested hold-off is counted down here, in cycles.
    always @(posedge clk) begin
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            check_result(rsp_if.data);
        rx_tick++;
        if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = hold_len - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  rsp_if.ready <= 1'b1;
                RX_RANDOM:  rsp_if.ready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: rsp_if.ready <= ((rx_tick % 7) > 1);
                default:    rsp_if.ready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("four_level_page_walker_test: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [VA_W-1:0] rand_va();
        logic [63:0] v;
        v = rand64();
        return v[VA_W-1:0];
    endfunction

    // Page-aligned table address strictly below the bound (may be zero)
    function automatic logic [PA_W-1:0] table_addr_below(input logic [PA_W-1:0] bnd);
        logic [63:0] a;
        a = rand64() % 64'(bnd);
        return PA_W'(a) & ADDR_MASK;
    endfunction

    // Page-aligned table address at or above the bound; ok is 0 if none fits
    function automatic logic [PA_W-1:0] table_addr_at_or_above(input logic [PA_W-1:0] bnd,
                                                               output bit ok);
        logic [63:0] lo_page;
        logic [63:0] page;
        lo_page = (64'(bnd) + 64'hFFF) >> PG_OFS;
        ok      = (lo_page < (64'd1 << (PA_W - PG_OFS)));
        if (!ok)
            return '0;
        // often right at the bound, otherwise anywhere above it
        if ($urandom_range(0, 3) == 0)
            page = lo_page;
        else
            page = lo_page + rand64() % ((64'd1 << (PA_W - PG_OFS)) - lo_page);
        return PA_W'(page << PG_OFS);
    endfunction

    // Present entry pointing at addr, large bit as given; other bits are random
    function automatic logic [63:0] table_entry(input logic [PA_W-1:0] addr,
                                                input bit is_large);
        logic [63:0] e;
        e                  = rand64();
        e[PA_W-1:PG_OFS]   = addr[PA_W-1:PG_OFS];
        e[ENT_PRESENT_BIT] = 1'b1;
        e[ENT_LARGE_BIT]   = is_large;
        return e;
    endfunction

    // Mostly a usable root, now and then a fully random (likely bad) one
    function automatic logic [PA_W-1:0] pick_root();
        logic [63:0] r;
        if ($urandom_range(0, 15) == 0) begin
            r = rand64();
            return r[PA_W-1:0];
        end
        return table_addr_below(table_bound);
    endfunction

    // Offer one request; return once it is taken. Bursts with random gaps.
    task automatic issue_request(input t_req r);
        int   gap;
        t_rsp res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, burst_max);
            if (gap_max != 0) begin
                gap = $urandom_range(0, gap_max);
                if (gap != 0) begin
                    req_if.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        burst_left--;
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge clk); while (req_if.ready !== 1'b1);
        if (walk_step(r, res)) begin
            expected_results.push_back(res);
            n_items++;
        end else begin
            n_ignored++;
        end
    endtask

    task automatic send_start(input logic [VA_W-1:0] va, input logic [PA_W-1:0] root);
        t_req        r;
        logic [63:0] junk;
        junk         = rand64();
        r.operation  = OP_START;
        r.virt_addr  = va;
        r.root_table = root;
        r.mem_data   = rand64();       // unused on a start
        r.mem_error  = junk[0];
        issue_request(r);
    endtask

    task automatic send_response(input logic [63:0] data, input bit err);
        t_req        r;
        logic [63:0] junk;
        junk         = rand64();
        r.operation  = OP_RSP;
        r.virt_addr  = rand_va();      // unused on a response
        r.root_table = junk[PA_W-1:0];
        r.mem_data   = data;
        r.mem_error  = err;
        issue_request(r);
    endtask

    // Stop offering and let every expected result come back
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_table_bound(input logic [PA_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        table_bound = value;
        n_bounds++;
    endtask

    // One walk with random content: mostly well-formed entries, sometimes a
    // read error, a missing entry, a table past the bound or a fresh start.
    task automatic run_walk(input logic [VA_W-1:0] va, input logic [PA_W-1:0] root);
        int              steps;
        int              pick;
        bit              ok;
        logic [PA_W-1:0] addr;
        send_start(va, root);
        steps = 0;
        while (walk_active && steps < 6) begin
            steps++;
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                send_start(rand_va(), pick_root());
            end else if (pick < 7) begin
                send_response(rand64(), 1'b1);
            end else if (pick < 11) begin
                send_response(rand64() & ~64'h1, 1'b0);
            end else if (pick < 15) begin
                addr = table_addr_at_or_above(table_bound, ok);
                send_response(ok ? table_entry(addr, 1'b0) : (rand64() & ~64'h1), 1'b0);
            end else begin
                send_response(table_entry(table_addr_below(table_bound),
                                          $urandom_range(0, 3) == 0), 1'b0);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Root checks against the bound left by reset
    task automatic test_bad_roots();
        send_start(rand_va(), '0);                            // zero root
        send_start(rand_va(), 52'h1001);                      // not page aligned
        send_start(48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF); // all ones
        send_start(rand_va(), BOUND_RESET);                   // exactly at the bound
        send_start(48'h0, BOUND_RESET - 52'h1000);            // last good root
        wait_idle();
    endtask

    // Every way a walk can end, plus the odd cases around it
    task automatic test_walk_endings();
        // full 4 KiB walk; large bit at the top level is not a page
        send_start(48'hFFFF_FFFF_FFFF, 52'h1000);
        send_response(table_entry(52'h2000, 1'b1), 1'b0);
        send_response(table_entry(52'h3000, 1'b0), 1'b0);
        send_response(table_entry(52'h4000, 1'b0), 1'b0);
        send_response(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);         // large bit ignored at leaf

        // 1 GiB page
        send_start(48'h0, 52'h5000);
        send_response(table_entry(52'h6000, 1'b0), 1'b0);
        send_response(table_entry(52'hF_FFFF_F000, 1'b1), 1'b0);

        // 2 MiB page
        send_start(rand_va(), 52'h7000);
        send_response(table_entry(52'h8000, 1'b0), 1'b0);
        send_response(table_entry(52'h9000, 1'b0), 1'b0);
        send_response(table_entry(52'hA000, 1'b1), 1'b0);

        // read error one level down
        send_start(rand_va(), 52'hB000);
        send_response(table_entry(52'hC000, 1'b0), 1'b0);
        send_response(table_entry(52'hD000, 1'b0), 1'b1);

        // next table exactly at the bound
        send_start(rand_va(), 52'hE000);
        send_response(table_entry(BOUND_RESET, 1'b0), 1'b0);

        // response with no walk running: dropped
        send_response(table_entry(52'h1000, 1'b0), 1'b0);

        // start during a walk drops it; then a missing entry
        send_start(rand_va(), 52'hF000);
        send_start(rand_va(), 52'h10000);
        send_response(table_entry(52'h11000, 1'b0), 1'b0);
        send_response(64'h0, 1'b0);

        // read error at the root level, data looks fine
        send_start(rand_va(), 52'h12000);
        send_response(table_entry(52'h13000, 1'b0), 1'b1);
        wait_idle();
    endtask

    // Consumer stops for a long stretch while requests keep coming,
    // so the result register fills and the request side stalls.
    task automatic test_backpressure();
        burst_max = 64;
        gap_max   = 0;
        rx_mode   = RX_ALWAYS;
        hold_len  = HOLD_CYCLES;
        hold_reqs++;
        repeat (3) run_walk(rand_va(), table_addr_below(table_bound));
        wait_idle();
    endtask

    // Random walks under several bounds and idling styles
    task automatic test_random_walks();
        int          phase;
        int          target;
        int          start_items;
        int          pick;
        logic [63:0] b;
        t_req        r;
        for (phase = 0; phase < 5; phase++) begin
            target = 170;
            case (phase)
                0: begin
                    write_table_bound({PA_W{1'b1}});          // widest bound
                    burst_max = 8;  gap_max = 6;  rx_mode = RX_RANDOM;
                end
                1: begin
                    write_table_bound(PA_W'(64'h1000));       // narrowest: every root bad
                    burst_max = 64; gap_max = 0;  rx_mode = RX_ALWAYS;
                    target = 20;
                end
                2: begin
                    b = rand64() % ((64'd1 << PA_W) - 64'h1000) + 64'h1000;
                    write_table_bound(PA_W'(b));
                    burst_max = 5;  gap_max = 3;  rx_mode = RX_PATTERN;
                end
                3: begin
                    b = (64'd1 << $urandom_range(20, 40)) | (rand64() & 64'hF_FFFF);
                    write_table_bound(PA_W'(b));
                    burst_max = 64; gap_max = 0;  rx_mode = RX_ALWAYS;
                end
                default: begin
                    b = rand64() % ((64'd1 << PA_W) - 64'h1000) + 64'h1000;
                    write_table_bound(PA_W'(b));
                    burst_max = 3;  gap_max = 10; rx_mode = RX_COIN;
                end
            endcase
            start_items = n_items;
            while (n_items < start_items + target) begin
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    run_walk(rand_va(), pick_root());
                end else if (pick < 92) begin
                    // stray response, dropped unless a walk is still open
                    send_response(rand64(), 1'($urandom_range(0, 1)));
                end else begin
                    b             = rand64();
                    r.operation   = t_op'(b[0]);
                    r.virt_addr   = rand_va();
                    b             = rand64();
                    r.root_table  = b[PA_W-1:0];
                    r.mem_data    = rand64();
                    r.mem_error   = 1'($urandom_range(0, 1));
                    issue_request(r);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        req_if.valid  = 1'b0;
        req_if.data   = '0;
        rsp_if.ready  = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_bad_roots();
        test_walk_endings();
        test_backpressure();
        test_random_walks();

        wait_idle();
        $display("Checked %0d results: %0d entry reads, %0d faults, %0d translations",
                 n_items, n_reads, n_fault, n_done);
        $display("Pages 4K/2M/1G: %0d/%0d/%0d; %0d stray responses; %0d bound settings",
                 n_4k, n_2m, n_1g, n_ignored, n_bounds);
        if (fail_count == 0) begin
            $display("four_level_page_walker_test: PASS");
        end else begin
            $display("four_level_page_walker_test: FAIL");
        end
        $finish;
    end

endmodule
